// ===== sv/slti_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted list table package
// Beat types, action and status codes, and the cell control types shared by
// the sorted list table modules.
// ----------------------------------------------------------------------------
package slti_pkg;

  // Action codes carried in the input beat.
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // Status codes carried in the result beat.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic [1:0]         status;
    logic               last;
  } out_beat_t;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE,
    CELL_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic signed [31:0] key;
  } cell_ctrl_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

// ===== sv/slti_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted list table cell
// One slot of the sorted chain: a value and an occupied bit. On insert it
// keeps, takes the new key or takes its left neighbor's value; on read-out
// it takes its right neighbor's value so that the list rotates by one place.
// ----------------------------------------------------------------------------
module slti_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  slti_pkg::cell_ctrl_t   ctrl,
  input  logic                   left_after,
  input  logic                   left_valid,
  input  logic signed [31:0]     left_value,
  input  logic                   right_valid,
  input  logic signed [31:0]     right_value,
  input  logic signed [31:0]     wrap_value,
  output logic                   valid,
  output logic signed [31:0]     value,
  output logic                   after
);

  // This cell lies at or past the insert point: it is free or holds a value
  // at least as large as the key. The chain is sorted, so this is monotone.
  assign after = !valid || (value >= ctrl.key);

  // Occupied bit: fills from the left on insert, drops on clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctrl.op)
        slti_pkg::CELL_INSERT: valid <= valid | left_valid;
        slti_pkg::CELL_CLEAR:  valid <= 1'b0;
        default:               valid <= valid;
      endcase
    end
  end

  // Value: the first cell at the insert point takes the key, those after it
  // shift right. On rotate the tail of the list takes the head's value.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      slti_pkg::CELL_INSERT: begin
        if (after && !left_after) begin
          value <= ctrl.key;
        end else if (after) begin
          value <= left_value;
        end
      end
      slti_pkg::CELL_ROTATE: begin
        if (valid) begin
          value <= right_valid ? right_value : wrap_value;
        end
      end
      default: begin
        value <= value;
      end
    endcase
  end

endmodule

// ===== sv/slti_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted list table controller
// Takes input beats, drives the cell chain and holds the result register.
// Read-out emits the head cell each cycle while the chain rotates. A stalled result side holds the read-out.
// ----------------------------------------------------------------------------
module slti_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  slti_pkg::in_beat_t     in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output slti_pkg::out_beat_t    out_data,
  input  logic [DEPTH-1:0]       cell_valid,
  input  logic signed [31:0]     head_value,
  output slti_pkg::cell_ctrl_t   cell_ctrl
);

  localparam int CW = $clog2(DEPTH);

  slti_pkg::state_t    state;
  slti_pkg::state_t    state_next;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       cnt_next;
  slti_pkg::out_beat_t out_next;
  logic                load_out;
  logic                slot_free;
  logic                accept;
  logic                full;
  logic                rd_last;
  logic [DEPTH-1:0]    valid_shr;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == slti_pkg::ST_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign full      = cell_valid[DEPTH-1];

  // The entry being read is the last one when the next cell is free.
  assign valid_shr = cell_valid >> 1;
  assign rd_last   = !valid_shr[cnt];

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      slti_pkg::ST_IDLE: begin
        if (accept && (in_data.action == slti_pkg::ACT_READ) && cell_valid[0]) begin
          state_next = slti_pkg::ST_READ;
        end
      end
      slti_pkg::ST_READ: begin
        if (slot_free && rd_last) begin
          state_next = slti_pkg::ST_IDLE;
        end
      end
      default: state_next = slti_pkg::ST_IDLE;
    endcase
  end

  // Cell commands, result beat and read counter.
  always_comb begin
    cell_ctrl.op  = slti_pkg::CELL_HOLD;
    cell_ctrl.key = in_data.value;
    load_out      = 1'b0;
    out_next      = '{value_out: 32'sd0, status: slti_pkg::STAT_OK, last: 1'b1};
    cnt_next      = cnt;
    unique case (state)
      slti_pkg::ST_IDLE: begin
        cnt_next = '0;
        if (accept) begin
          load_out = 1'b1;
          case (in_data.action)
            slti_pkg::ACT_INSERT: begin
              if (full) begin
                out_next.status = slti_pkg::STAT_FULL;
              end else begin
                cell_ctrl.op = slti_pkg::CELL_INSERT;
              end
            end
            slti_pkg::ACT_READ: begin
              if (!cell_valid[0]) begin
                out_next.status = slti_pkg::STAT_EMPTY;
              end else begin
                load_out = 1'b0;
              end
            end
            slti_pkg::ACT_CLEAR: begin
              cell_ctrl.op = slti_pkg::CELL_CLEAR;
            end
            default: begin
              cell_ctrl.op = slti_pkg::CELL_HOLD;
            end
          endcase
        end
      end
      slti_pkg::ST_READ: begin
        if (slot_free) begin
          load_out           = 1'b1;
          out_next.value_out = head_value;
          out_next.last      = rd_last;
          cell_ctrl.op       = slti_pkg::CELL_ROTATE;
          cnt_next           = cnt + 1'b1;
        end
      end
      default: begin
        cnt_next = '0;
      end
    endcase
  end

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slti_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= out_next;
    end
  end

  // Occupied cells always form one unbroken run from the head.
  a_valid_run: assert property (@(posedge clk) disable iff (rst)
    (cell_valid & (cell_valid + 1'b1)) == '0)
    else $error("occupied cells are not contiguous");

  // A read-out in progress always has a head entry.
  a_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == slti_pkg::ST_READ) |-> cell_valid[0])
    else $error("read-out running on an empty list");

  // A successful insert adds exactly one entry.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_data.action == slti_pkg::ACT_INSERT) && !full) |=>
      ($countones(cell_valid) == $countones($past(cell_valid)) + 1))
    else $error("insert did not add one entry");

  // A clear leaves the table empty.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_data.action == slti_pkg::ACT_CLEAR)) |=> (cell_valid == '0))
    else $error("clear left entries behind");

endmodule

// ===== sv/sorted_list_table_insert.sv =====
// ----------------------------------------------------------------------------
// Sorted list table insert
// Table of signed values kept in ascending order in a chain of cells.
// ----------------------------------------------------------------------------
// The table is a row of TABLE_DEPTH cells holding the list in ascending order
// from cell 0, so a new value lands ahead of equal ones. An insert, a clear or
// an unused action code is done in the cycle the input beat is accepted, and
// its single result beat is offered in the next cycle. A read-out of n entries
// gives n result beats, one per cycle while the result side does not stall:
// each such cycle the head cell is emitted and the chain rotates by one place,
// so after the last beat the list is back in place. An empty list gives one
// beat with the empty status. A new input beat is taken once the read-out has
// finished and the result register is free or being emptied.
module sorted_list_table_insert #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  slti_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output slti_pkg::out_beat_t out_data
);

  slti_pkg::cell_ctrl_t     cell_ctrl;
  logic [TABLE_DEPTH-1:0]   cell_valid;
  logic [TABLE_DEPTH-1:0]   cell_after;
  logic signed [31:0]       cell_value [TABLE_DEPTH];

  // Control and result register.
  slti_ctrl #(
    .DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cell_valid (cell_valid),
    .head_value (cell_value[0]),
    .cell_ctrl  (cell_ctrl)
  );

  // Chain of cells; the ends see a fixed neighbor.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic               left_after;
    logic               left_valid;
    logic signed [31:0] left_value;
    logic               right_valid;
    logic signed [31:0] right_value;

    if (i == 0) begin : g_first
      assign left_after = 1'b0;
      assign left_valid = 1'b1;
      assign left_value = cell_ctrl.key;
    end else begin : g_inner_left
      assign left_after = cell_after[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_value = cell_value[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_valid = 1'b0;
      assign right_value = cell_value[0];
    end else begin : g_inner_right
      assign right_valid = cell_valid[i+1];
      assign right_value = cell_value[i+1];
    end

    slti_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (cell_ctrl),
      .left_after  (left_after),
      .left_valid  (left_valid),
      .left_value  (left_value),
      .right_valid (right_valid),
      .right_value (right_value),
      .wrap_value  (cell_value[0]),
      .valid       (cell_valid[i]),
      .value       (cell_value[i]),
      .after       (cell_after[i])
    );
  end

endmodule

// ===== sim/tb_sorted_list_table_insert.sv =====
// ----------------------------------------------------------------------------
// Sorted list table insert testbench
// Sends insert, read-out, clear and unused action beats through the block and
// checks every result beat against a predictor that keeps its own copy of the
// slot table, the links and the list head.
// ----------------------------------------------------------------------------
module tb_sorted_list_table_insert;

  localparam int         TABLE_DEPTH  = 16;
  localparam int         END_SLOT     = TABLE_DEPTH;
  localparam logic [1:0] ACT_NOP      = 2'd3;
  localparam int         IDLE_LIMIT   = 5000;
  localparam int         RANDOM_ITEMS = 290;
  localparam int         TAIL_CYCLES  = 40;

  // Patterns of the result side's ready signal, picked at random.
  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_ALTERNATE,
    RDY_MOSTLY,
    RDY_SPARSE
  } ready_mode_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  slti_pkg::in_beat_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  slti_pkg::out_beat_t out_data;

  // Predicted slot table: key, busy bit and link of every slot.
  logic signed [31:0]  slot_key  [TABLE_DEPTH];
  logic                slot_used [TABLE_DEPTH];
  logic [4:0]          slot_next [TABLE_DEPTH];
  logic [4:0]          list_head;
  slti_pkg::out_beat_t pending_results [$];

  int          fail_count  = 0;
  int          idle_cycles = 0;
  int          burst_left  = 1;
  ready_mode_t ready_mode  = RDY_ALWAYS;
  int          ready_phase = 0;

  sorted_list_table_insert #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Free every slot and empty the predicted list.
  function automatic void empty_list();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i]  = '0;
      slot_next[i] = END_SLOT[4:0];
    end
    list_head = END_SLOT[4:0];
  endfunction

  function automatic void push_result(logic signed [31:0] v, logic [1:0] st, logic lst);
    slti_pkg::out_beat_t r;
    r.value_out = v;
    r.status    = st;
    r.last      = lst;
    pending_results.push_back(r);
  endfunction

  // Place a key in the lowest free slot and link it ahead of the first entry
  // that is not smaller. Returns the status of the insert.
  function automatic logic [1:0] insert_key(logic signed [31:0] key);
    int         free_slot;
    logic [4:0] prev;
    logic [4:0] cur;
    free_slot = -1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!slot_used[i] && free_slot < 0) free_slot = i;
    end
    if (free_slot < 0) return slti_pkg::STAT_FULL;
    slot_used[free_slot] = 1'b1;
    slot_key[free_slot]  = key;
    if (list_head == END_SLOT || slot_key[list_head] >= key) begin
      slot_next[free_slot] = list_head;
      list_head            = free_slot[4:0];
    end else begin
      prev = list_head;
      cur  = slot_next[prev];
      while (cur != END_SLOT && slot_key[cur] < key) begin
        prev = cur;
        cur  = slot_next[cur];
      end
      slot_next[prev]      = free_slot[4:0];
      slot_next[free_slot] = cur;
    end
    return slti_pkg::STAT_OK;
  endfunction

  // Update the predicted table for one accepted beat and queue its results.
  function automatic void apply_list_action(slti_pkg::in_beat_t item);
    logic [4:0] cur;
    int         n;
    case (item.action)
      slti_pkg::ACT_INSERT: push_result('0, insert_key(item.value), 1'b1);
      slti_pkg::ACT_READ: begin
        if (list_head == END_SLOT) begin
          push_result('0, slti_pkg::STAT_EMPTY, 1'b1);
        end else begin
          cur = list_head;
          n   = 0;
          while (cur != END_SLOT && n < TABLE_DEPTH) begin
            push_result(slot_key[cur], slti_pkg::STAT_OK,
                        (slot_next[cur] == END_SLOT) || (n + 1 >= TABLE_DEPTH));
            n++;
            cur = slot_next[cur];
          end
        end
      end
      slti_pkg::ACT_CLEAR: begin
        empty_list();
        push_result('0, slti_pkg::STAT_OK, 1'b1);
      end
      default: push_result('0, slti_pkg::STAT_OK, 1'b1);
    endcase
  endfunction

  // Random key: wide values, small clusters near zero and near 1000 for duplicates, extremes.
  function automatic logic signed [31:0] random_key();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6: begin
        v = $urandom_range(0, 8);
        return v - 4;
      end
      7: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return 32'sh7FFF_FFFF - $urandom_range(0, 3);
          default: return 32'sh8000_0000 + $urandom_range(0, 3);
        endcase
      end
      default: return 1000 + $urandom_range(0, 3);
    endcase
  endfunction

  // Offer one input beat and hold it until it is taken. The sender works in
  // bursts; valid drops only when a burst ends, and then stays low a while.
  task automatic send_beat(input logic [1:0] action, input logic signed [31:0] value);
    slti_pkg::in_beat_t item;
    int                 gap;
    item.action = action;
    item.value  = value;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    apply_list_action(item);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 50)
                                               : $urandom_range(1, 8);
    end
  endtask

  // Extremes of the value field, duplicates, every action and the empty list.
  task automatic test_edge_values();
    send_beat(slti_pkg::ACT_READ, 32'sh0);
    send_beat(slti_pkg::ACT_INSERT, 32'sh0);
    send_beat(slti_pkg::ACT_INSERT, 32'sh7FFF_FFFF);
    send_beat(slti_pkg::ACT_INSERT, 32'sh8000_0000);
    send_beat(slti_pkg::ACT_INSERT, -32'sd1);
    send_beat(slti_pkg::ACT_INSERT, 32'sh8000_0000);
    send_beat(slti_pkg::ACT_INSERT, 32'sh1);
    send_beat(slti_pkg::ACT_INSERT, 32'sh0);
    send_beat(slti_pkg::ACT_READ, 32'sh7FFF_FFFF);
    send_beat(ACT_NOP, -32'sd1);
    send_beat(slti_pkg::ACT_READ, 32'sh0);
    send_beat(slti_pkg::ACT_CLEAR, 32'sh5555_5555);
    send_beat(slti_pkg::ACT_READ, 32'shAAAA_AAAA);
    send_beat(slti_pkg::ACT_INSERT, 32'sh7FFF_FFFF);
    send_beat(slti_pkg::ACT_READ, 32'sh0);
    send_beat(slti_pkg::ACT_CLEAR, 32'sh0);
  endtask

  // Fill every slot, then insert into the full table, read all entries, clear and read the empty table.
  task automatic test_full_table();
    for (int i = 0; i < TABLE_DEPTH; i++) send_beat(slti_pkg::ACT_INSERT, (i * 7) % 11 - 5);
    send_beat(slti_pkg::ACT_INSERT, 32'sh8000_0000);
    send_beat(slti_pkg::ACT_READ, 32'sh0);
    send_beat(slti_pkg::ACT_INSERT, 32'sh7FFF_FFFF);
    send_beat(slti_pkg::ACT_CLEAR, 32'sh0);
    send_beat(slti_pkg::ACT_READ, 32'sh0);
  endtask

  // Mostly inserts and read-outs with occasional clears, unused action codes
  // and fill-then-read episodes that can reach the full table.
  task automatic test_random_traffic();
    int sent;
    int pick;
    int fill;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
        send_beat(slti_pkg::ACT_INSERT, random_key());
        sent++;
      end else if (pick < 78) begin
        send_beat(slti_pkg::ACT_READ, $urandom);
        sent++;
      end else if (pick < 83) begin
        send_beat(slti_pkg::ACT_CLEAR, $urandom);
        sent++;
      end else if (pick < 87) begin
        send_beat(ACT_NOP, $urandom);
        sent++;
      end else begin
        fill = $urandom_range(1, TABLE_DEPTH + 2);
        send_beat(slti_pkg::ACT_CLEAR, $urandom);
        for (int i = 0; i < fill; i++) send_beat(slti_pkg::ACT_INSERT, random_key());
        send_beat(slti_pkg::ACT_READ, $urandom);
        sent += fill + 2;
      end
    end
  endtask

  // The result side stalls on a pattern picked at random, which changes when its phase count runs out.
  always @(posedge clk) begin
    if (ready_phase == 0) begin
      ready_mode  <= ready_mode_t'($urandom_range(0, 3));
      ready_phase <= $urandom_range(20, 120);
    end else begin
      ready_phase <= ready_phase - 1;
    end
    case (ready_mode)
      RDY_ALWAYS:    out_ready <= 1'b1;
      RDY_ALTERNATE: out_ready <= ready_phase[0];
      RDY_MOSTLY:    out_ready <= ($urandom_range(0, 3) != 0);
      default:       out_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // Compare each result beat with the oldest predicted one.
  always @(posedge clk) begin
    slti_pkg::out_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected beat, value_out %0d status %0d last %0b", $time,
                 out_data.value_out, out_data.status, out_data.last);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.value_out !== want.value_out) begin
          $display("%0t: value_out expected %0d got %0d", $time,
                   want.value_out, out_data.value_out);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, out_data.status);
          fail_count++;
        end
        if (out_data.last !== want.last) begin
          $display("%0t: last expected %0b got %0b", $time, want.last, out_data.last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    empty_list();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_edge_values();
    test_full_table();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/slti_pkg.sv
sv/slti_cell.sv
sv/slti_ctrl.sv
sv/sorted_list_table_insert.sv
sim/tb_sorted_list_table_insert.sv
